>>> sv/ognz_pkg.sv
// shared types, constants and helper functions for the octave gradient noise block
package ognz_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int VAL_W      = 24;
    localparam int MUL_W      = 2 * VAL_W;
    localparam int RES_W      = 32;
    localparam int OUT_W      = 16;
    localparam int TABLE_SIZE = 256;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int OCTAVE_MAX = 8;
    localparam int OCT_W      = 4;
    localparam int OCT_IDX_W  = $clog2(OCTAVE_MAX);
    localparam int CFG_IDX_W  = 2;
    localparam int OP_W       = 6;

    localparam logic signed [VAL_W-1:0] ONE     = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] FIFTEEN = VAL_W'(15 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] TEN     = VAL_W'(10 << FRAC_BITS);

    // micro-op numbers of one octave
    localparam logic [OP_W-1:0] OP_FADE_LAST = 6'd11;
    localparam logic [OP_W-1:0] OP_RD_X      = 6'd12;
    localparam logic [OP_W-1:0] OP_RD_X1     = 6'd13;
    localparam logic [OP_W-1:0] OP_RD_A      = 6'd14;
    localparam logic [OP_W-1:0] OP_RD_A1     = 6'd15;
    localparam logic [OP_W-1:0] OP_RD_B      = 6'd16;
    localparam logic [OP_W-1:0] OP_RD_B1     = 6'd17;
    localparam logic [OP_W-1:0] OP_CORNER    = 6'd18;
    localparam logic [OP_W-1:0] OP_LERP      = 6'd26;
    localparam logic [OP_W-1:0] OP_LAST      = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OCTAVES = 2'd0,
        CFG_OUT_MIN = 2'd1,
        CFG_OUT_MAX = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_ACC,
        S_FIN0,
        S_FIN1
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    half;
    } t_mul_req;

    function automatic logic signed [VAL_W-1:0] grad(
        input logic [3:0]              h,
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y,
        input logic signed [VAL_W-1:0] z
    );
        logic signed [VAL_W-1:0] u;
        logic signed [VAL_W-1:0] v;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            v = y;
        end else if (h == 4'd12 || h == 4'd14) begin
            v = x;
        end else begin
            v = z;
        end
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    // arithmetic shift that rounds toward zero
    function automatic logic signed [VAL_W-1:0] shr_tz(
        input logic signed [VAL_W-1:0] v,
        input logic [OCT_IDX_W-1:0]    s
    );
        logic signed [VAL_W-1:0] bias;
        bias = v[VAL_W-1] ? ((VAL_W'(1) << s) - VAL_W'(1)) : '0;
        return (v + bias) >>> s;
    endfunction

endpackage

>>> sv/ognz_ifs.sv
// request, result and configuration channel interfaces
interface ognz_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ognz_pkg::COORD_W-1:0] coord_x;
    logic [ognz_pkg::COORD_W-1:0] coord_y;
    logic [ognz_pkg::COORD_W-1:0] coord_z;
    logic [ognz_pkg::ADDR_W-1:0]  table_index;
    logic [ognz_pkg::ADDR_W-1:0]  table_value;
    modport source(output valid, req_type, coord_x, coord_y, coord_z, table_index,
                   table_value, input ready);
    modport sink(input valid, req_type, coord_x, coord_y, coord_z, table_index,
                 table_value, output ready);
endinterface

interface ognz_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [ognz_pkg::OUT_W-1:0] noise_value;
    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

interface ognz_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ognz_pkg::CFG_IDX_W-1:0] index;
    logic [ognz_pkg::OUT_W-1:0]     data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> sv/ognz_mul.sv
// shared fixed-point multiplier with registered product and toward-zero scaling
module ognz_mul (
    input  logic                                  i_clk,
    input  ognz_pkg::t_mul_req                    i_mreq,
    output logic signed [ognz_pkg::RES_W-1:0]     o_res
);
    logic signed [ognz_pkg::MUL_W-1:0] r_prod;
    logic                              r_half;
    logic signed [ognz_pkg::MUL_W-1:0] w_bias;
    logic signed [ognz_pkg::MUL_W-1:0] w_shifted;

    always_ff @(posedge i_clk) begin
        r_prod <= ognz_pkg::MUL_W'(i_mreq.a) * ognz_pkg::MUL_W'(i_mreq.b);
        r_half <= i_mreq.half;
    end

    always_comb begin
        if (r_prod[ognz_pkg::MUL_W-1]) begin
            w_bias = r_half ? ognz_pkg::MUL_W'((1 << (ognz_pkg::FRAC_BITS + 1)) - 1)
                            : ognz_pkg::MUL_W'((1 << ognz_pkg::FRAC_BITS) - 1);
        end else begin
            w_bias = '0;
        end
        w_shifted = (r_prod + w_bias) >>> (ognz_pkg::FRAC_BITS + (r_half ? 1 : 0));
        o_res     = w_shifted[ognz_pkg::RES_W-1:0];
    end
endmodule

>>> sv/octave_gradient_noise_3d.sv
// top level: sequencer, permutation memory and datapath registers around one multiplier
// An evaluation request runs each octave as 33 micro-steps through the single shared
// multiplier and the single port of the permutation memory, then an accumulate step;
// after the last octave, the states S_FIN0 and S_FIN1 map the sum onto the output range.
// A table load request writes one entry and gives no result. All 256 table entries must
// be loaded before the first evaluation. A finished result waits in the output register
// while the next request is accepted.
module octave_gradient_noise_3d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ognz_req_if.sink     i_req,
    ognz_res_if.source   o_res,
    ognz_cfg_if.sink     i_cfg
);
    localparam int VW = ognz_pkg::VAL_W;
    localparam int AW = ognz_pkg::ADDR_W;

    ognz_pkg::t_state r_state, n_state;

    logic [ognz_pkg::OCT_W-1:0]      r_octaves;
    logic signed [ognz_pkg::OUT_W-1:0] r_out_min, r_out_max;

    logic [AW-1:0] r_perm [ognz_pkg::TABLE_SIZE];
    logic [AW-1:0] r_rdata;
    logic [AW-1:0] w_addr;

    logic [ognz_pkg::OP_W-1:0]      r_op;
    logic                           r_ph;
    logic [ognz_pkg::OCT_IDX_W-1:0] r_oct_i;
    logic [ognz_pkg::OCT_W-1:0]     r_oct_lim;
    logic [ognz_pkg::COORD_W-1:0]   r_cx, r_cy, r_cz;
    logic signed [VW-1:0]           r_fade [3];
    logic signed [VW-1:0]           r_t2, r_t3, r_in;
    logic [AW-1:0]                  r_a, r_b, r_aa, r_ab, r_ba, r_bb;
    logic [3:0]                     r_h [8];
    logic signed [VW-1:0]           r_l [4];
    logic signed [VW-1:0]           r_n;
    logic signed [VW-1:0]           r_sum;
    logic                           r_out_valid;
    logic signed [ognz_pkg::OUT_W-1:0] r_out;

    ognz_pkg::t_mul_req                 w_mreq;
    logic signed [ognz_pkg::RES_W-1:0]  w_res;

    logic                 w_accept;
    logic                 w_out_free;
    logic [1:0]           w_axis;
    logic [1:0]           w_sub;
    logic signed [VW-1:0] w_t;
    logic [ognz_pkg::OP_W-1:0] w_rel;
    logic [2:0]           w_k;
    logic [2:0]           w_ka, w_kb;
    logic signed [VW-1:0] w_fx, w_fy, w_fz;
    logic signed [VW-1:0] w_la, w_lb;
    logic [AW-1:0]        w_base;
    logic signed [ognz_pkg::RES_W:0] w_r;
    logic signed [ognz_pkg::RES_W:0] w_lo, w_hi;
    logic signed [ognz_pkg::OUT_W:0] w_span;

    ognz_mul u_mul (
        .i_clk  (i_clk),
        .i_mreq (w_mreq),
        .o_res  (w_res)
    );

    assign i_req.ready       = (r_state == ognz_pkg::S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.noise_value = r_out;
    assign w_accept          = i_req.valid && i_req.ready;
    assign w_out_free        = !r_out_valid || o_res.ready;

    // operand decode for the current micro-step
    always_comb begin
        w_axis = r_op[3:2];
        w_sub  = r_op[1:0];
        w_fx   = VW'(r_cx[ognz_pkg::FRAC_BITS-1:0]);
        w_fy   = VW'(r_cy[ognz_pkg::FRAC_BITS-1:0]);
        w_fz   = VW'(r_cz[ognz_pkg::FRAC_BITS-1:0]);
        case (w_axis)
            2'd0:    w_t = w_fx;
            2'd1:    w_t = w_fy;
            default: w_t = w_fz;
        endcase
        w_rel = r_op - ognz_pkg::OP_CORNER;
        w_k   = w_rel[2:0];
        case (w_k[1:0])
            2'd0:    w_base = r_aa;
            2'd1:    w_base = r_ba;
            2'd2:    w_base = r_ab;
            default: w_base = r_bb;
        endcase
        case (r_op)
            ognz_pkg::OP_RD_X:  w_addr = r_cx[ognz_pkg::COORD_W-1 -: AW];
            ognz_pkg::OP_RD_X1: w_addr = r_cx[ognz_pkg::COORD_W-1 -: AW] + AW'(1);
            ognz_pkg::OP_RD_A:  w_addr = r_a;
            ognz_pkg::OP_RD_A1: w_addr = r_a + AW'(1);
            ognz_pkg::OP_RD_B:  w_addr = r_b;
            ognz_pkg::OP_RD_B1: w_addr = r_b + AW'(1);
            default:            w_addr = w_base + AW'(w_k[2]);
        endcase

        // lerp operands: x pairs first, then y pairs, then the z blend
        w_rel = r_op - ognz_pkg::OP_LERP;
        w_ka  = {w_rel[1:0], 1'b0};
        w_kb  = {w_rel[1:0], 1'b1};
        if (w_rel < 6'd4) begin
            w_la = ognz_pkg::grad(r_h[w_ka], w_fx, w_ka[1] ? w_fy - ognz_pkg::ONE : w_fy,
                                  w_ka[2] ? w_fz - ognz_pkg::ONE : w_fz);
            w_lb = ognz_pkg::grad(r_h[w_kb], w_fx - ognz_pkg::ONE,
                                  w_kb[1] ? w_fy - ognz_pkg::ONE : w_fy,
                                  w_kb[2] ? w_fz - ognz_pkg::ONE : w_fz);
        end else if (w_rel == 6'd5) begin
            w_la = r_l[2];
            w_lb = r_l[3];
        end else begin
            w_la = r_l[0];
            w_lb = r_l[1];
        end

        w_mreq.half = 1'b0;
        w_mreq.a    = '0;
        w_mreq.b    = '0;
        w_span      = (ognz_pkg::OUT_W+1)'(r_out_max) - (ognz_pkg::OUT_W+1)'(r_out_min);
        if (r_state == ognz_pkg::S_FIN0 || r_state == ognz_pkg::S_FIN1) begin
            w_mreq.a    = r_sum + ognz_pkg::ONE;
            w_mreq.b    = VW'(w_span);
            w_mreq.half = 1'b1;
        end else if (r_op <= ognz_pkg::OP_FADE_LAST) begin
            case (w_sub)
                2'd0: begin
                    w_mreq.a = w_t;
                    w_mreq.b = w_t;
                end
                2'd1: begin
                    w_mreq.a = r_t2;
                    w_mreq.b = w_t;
                end
                2'd2: begin
                    w_mreq.a = w_t;
                    w_mreq.b = (w_t <<< 2) + (w_t <<< 1) - ognz_pkg::FIFTEEN;
                end
                default: begin
                    w_mreq.a = r_t3;
                    w_mreq.b = r_in;
                end
            endcase
        end else begin
            if (w_rel < 6'd4) begin
                w_mreq.a = r_fade[0];
            end else if (w_rel < 6'd6) begin
                w_mreq.a = r_fade[1];
            end else begin
                w_mreq.a = r_fade[2];
            end
            w_mreq.b = w_lb - w_la;
        end

        w_r  = (ognz_pkg::RES_W+1)'(r_out_min) + (ognz_pkg::RES_W+1)'(w_res);
        w_lo = (ognz_pkg::RES_W+1)'(r_out_min);
        w_hi = (ognz_pkg::RES_W+1)'(r_out_max);
        if (w_r < w_lo) w_r = w_lo;
        if (w_r > w_hi) w_r = w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ognz_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ognz_pkg::S_IDLE: begin
                if (w_accept && !i_req.req_type) n_state = ognz_pkg::S_OP;
            end
            ognz_pkg::S_OP: begin
                if (r_ph && r_op == ognz_pkg::OP_LAST) n_state = ognz_pkg::S_ACC;
            end
            ognz_pkg::S_ACC: begin
                if (ognz_pkg::OCT_W'(r_oct_i) + ognz_pkg::OCT_W'(1) == r_oct_lim) begin
                    n_state = ognz_pkg::S_FIN0;
                end else begin
                    n_state = ognz_pkg::S_OP;
                end
            end
            ognz_pkg::S_FIN0: n_state = ognz_pkg::S_FIN1;
            ognz_pkg::S_FIN1: begin
                if (w_out_free) n_state = ognz_pkg::S_IDLE;
            end
            default: n_state = ognz_pkg::S_IDLE;
        endcase
    end

    // configuration registers and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves   <= ognz_pkg::OCT_W'(1);
            r_out_min   <= 16'sh8000;
            r_out_max   <= 16'sh7fff;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    ognz_pkg::CFG_OCTAVES: r_octaves <= i_cfg.data[ognz_pkg::OCT_W-1:0];
                    ognz_pkg::CFG_OUT_MIN: r_out_min <= i_cfg.data;
                    ognz_pkg::CFG_OUT_MAX: r_out_max <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == ognz_pkg::S_FIN1 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // permutation memory
    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.req_type) begin
            r_perm[i_req.table_index] <= i_req.table_value;
        end
        r_rdata <= r_perm[w_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
            r_ph <= 1'b0;
        end else begin
            unique case (r_state)
                ognz_pkg::S_IDLE: begin
                    if (w_accept && !i_req.req_type) begin
                        r_cx    <= i_req.coord_x;
                        r_cy    <= i_req.coord_y;
                        r_cz    <= i_req.coord_z;
                        r_op    <= '0;
                        r_ph    <= 1'b0;
                        r_oct_i <= '0;
                        r_sum   <= '0;
                        if (r_octaves == '0) begin
                            r_oct_lim <= ognz_pkg::OCT_W'(1);
                        end else if (r_octaves > ognz_pkg::OCT_W'(ognz_pkg::OCTAVE_MAX)) begin
                            r_oct_lim <= ognz_pkg::OCT_W'(ognz_pkg::OCTAVE_MAX);
                        end else begin
                            r_oct_lim <= r_octaves;
                        end
                    end
                end
                ognz_pkg::S_OP: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_op <= r_op + ognz_pkg::OP_W'(1);
                        if (r_op <= ognz_pkg::OP_FADE_LAST) begin
                            case (w_sub)
                                2'd0:    r_t2 <= w_res[VW-1:0];
                                2'd1:    r_t3 <= w_res[VW-1:0];
                                2'd2:    r_in <= w_res[VW-1:0] + ognz_pkg::TEN;
                                default: r_fade[w_axis] <= w_res[VW-1:0];
                            endcase
                        end else if (r_op < ognz_pkg::OP_CORNER) begin
                            case (r_op)
                                ognz_pkg::OP_RD_X:  r_a  <= r_rdata + r_cy[ognz_pkg::COORD_W-1 -: AW];
                                ognz_pkg::OP_RD_X1: r_b  <= r_rdata + r_cy[ognz_pkg::COORD_W-1 -: AW];
                                ognz_pkg::OP_RD_A:  r_aa <= r_rdata + r_cz[ognz_pkg::COORD_W-1 -: AW];
                                ognz_pkg::OP_RD_A1: r_ab <= r_rdata + r_cz[ognz_pkg::COORD_W-1 -: AW];
                                ognz_pkg::OP_RD_B:  r_ba <= r_rdata + r_cz[ognz_pkg::COORD_W-1 -: AW];
                                default:            r_bb <= r_rdata + r_cz[ognz_pkg::COORD_W-1 -: AW];
                            endcase
                        end else if (r_op < ognz_pkg::OP_LERP) begin
                            r_h[w_k] <= r_rdata[3:0];
                        end else if (w_rel < 6'd4) begin
                            r_l[w_rel[1:0]] <= w_la + w_res[VW-1:0];
                        end else if (w_rel < 6'd6) begin
                            r_l[{1'b0, w_rel[0]}] <= w_la + w_res[VW-1:0];
                        end else begin
                            r_n <= w_la + w_res[VW-1:0];
                        end
                    end
                end
                ognz_pkg::S_ACC: begin
                    r_sum   <= r_sum + ognz_pkg::shr_tz(r_n, r_oct_i);
                    r_oct_i <= r_oct_i + ognz_pkg::OCT_IDX_W'(1);
                    r_cx    <= r_cx << 1;
                    r_cy    <= r_cy << 1;
                    r_cz    <= r_cz << 1;
                    r_op    <= '0;
                    r_ph    <= 1'b0;
                end
                ognz_pkg::S_FIN0: ;
                ognz_pkg::S_FIN1: begin
                    if (w_out_free) r_out <= w_r[ognz_pkg::OUT_W-1:0];
                end
                default: ;
            endcase
        end
    end
endmodule

>>> tb/sv/ognz_tb_ifs.sv
// testbench request record shared by the driving tasks and the scoreboard
package ognz_tb_types;
    typedef struct {
        logic        req_type;
        logic [23:0] cx;
        logic [23:0] cy;
        logic [23:0] cz;
        logic [7:0]  idx;
        logic [7:0]  val;
    } t_noise_req;
endpackage

>>> tb/sv/octave_gradient_noise_3d_tb.sv
// testbench for the octave gradient noise block: predicts each noise value and checks results
module octave_gradient_noise_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class noise_scoreboard;
        logic [7:0] perm_mem [256];
        int unsigned octaves = 1;
        longint lo = -32768;
        longint hi = 32767;
        logic signed [15:0] pending [$];
        int mismatches = 0;
        int checked = 0;

        function longint tz_shift(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = m >>> s;
            return (v < 0) ? -m : m;
        endfunction

        function longint fx_mul(longint a, longint b);
            return tz_shift(a * b, 16);
        endfunction

        function longint fade(longint t);
            longint t3;
            longint inner;
            t3 = fx_mul(fx_mul(t, t), t);
            inner = fx_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
            return fx_mul(t3, inner);
        endfunction

        function longint blend(longint t, longint a, longint b);
            return a + fx_mul(t, b - a);
        endfunction

        function longint corner(int h, longint x, longint y, longint z);
            longint u;
            longint v;
            h = h & 15;
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
            if (h & 1) u = -u;
            if (h & 2) v = -v;
            return u + v;
        endfunction

        function int pm(int i);
            return int'(perm_mem[i & 255]);
        endfunction

        function longint lattice_noise(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
            int xi, yi, zi, a, aa, ab, b, ba, bb;
            longint x, y, z, u, v, w, x1, y1, z1, n0, n1;
            xi = int'(cx[23:16]); yi = int'(cy[23:16]); zi = int'(cz[23:16]);
            x = longint'(cx[15:0]); y = longint'(cy[15:0]); z = longint'(cz[15:0]);
            u = fade(x); v = fade(y); w = fade(z);
            a = pm(xi) + yi; aa = pm(a) + zi; ab = pm(a + 1) + zi;
            b = pm(xi + 1) + yi; ba = pm(b) + zi; bb = pm(b + 1) + zi;
            x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
            n0 = blend(v, blend(u, corner(pm(aa), x, y, z), corner(pm(ba), x1, y, z)),
                          blend(u, corner(pm(ab), x, y1, z), corner(pm(bb), x1, y1, z)));
            n1 = blend(v, blend(u, corner(pm(aa + 1), x, y, z1), corner(pm(ba + 1), x1, y, z1)),
                          blend(u, corner(pm(ab + 1), x, y1, z1),
                                corner(pm(bb + 1), x1, y1, z1)));
            return blend(w, n0, n1);
        endfunction

        function void set_reg(ognz_pkg::t_cfg_idx idx, logic [15:0] d);
            case (idx)
                ognz_pkg::CFG_OCTAVES: octaves = int'(d[3:0]);
                ognz_pkg::CFG_OUT_MIN: lo = longint'($signed(d));
                ognz_pkg::CFG_OUT_MAX: hi = longint'($signed(d));
                default: ;
            endcase
        endfunction

        function void note_request(ognz_tb_types::t_noise_req r);
            int n;
            longint sum, r2;
            if (r.req_type) begin
                perm_mem[r.idx] = r.val;
                return;
            end
            n = (octaves < 1) ? 1 :
                ((octaves > ognz_pkg::OCTAVE_MAX) ? ognz_pkg::OCTAVE_MAX : int'(octaves));
            sum = 0;
            for (int i = 0; i < n; i++) begin
                sum += tz_shift(lattice_noise(24'(r.cx << i), 24'(r.cy << i), 24'(r.cz << i)), i);
            end
            r2 = lo + tz_shift((sum + 65536) * (hi - lo), 17);
            if (r2 < lo) r2 = lo;
            if (r2 > hi) r2 = hi;
            pending.push_back(16'(r2));
        endfunction

        function void check_result(logic signed [15:0] got);
            logic signed [15:0] exp_v;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", got);
                return;
            end
            exp_v = pending.pop_front();
            checked++;
            if (got !== exp_v) begin
                mismatches++;
                if (mismatches <= 10) $display("noise_value mismatch: exp %0d got %0d", exp_v, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ognz_req_if req_ch();
    ognz_res_if res_ch();
    ognz_cfg_if cfg_ch();

    octave_gradient_noise_3d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_res(res_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    noise_scoreboard sb = new();
    longint cycles = 0;
    bit hold_off = 0;
    int evals = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sampling on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            ognz_tb_types::t_noise_req r;
            r.req_type = req_ch.req_type; r.cx = req_ch.coord_x; r.cy = req_ch.coord_y;
            r.cz = req_ch.coord_z; r.idx = req_ch.table_index; r.val = req_ch.table_value;
            sb.note_request(r);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.noise_value);
    end

    // result side: random stalls, with one long hold-off on request
    initial begin
        int g;
        res_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 0;
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end
            g = $urandom_range(0, 9);
            if (g < 6) res_ch.ready <= 1;
            else if (g < 9) res_ch.ready <= 0;
            else begin
                res_ch.ready <= 0;
                repeat ($urandom_range(20, 200)) @(negedge i_clk);
            end
        end
    end

    task automatic send(ognz_tb_types::t_noise_req r);
        req_ch.valid <= 1;
        req_ch.req_type <= r.req_type;
        req_ch.coord_x <= r.cx; req_ch.coord_y <= r.cy; req_ch.coord_z <= r.cz;
        req_ch.table_index <= r.idx; req_ch.table_value <= r.val;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            req_ch.valid <= 0;
            if ($urandom_range(0, 15) == 0) repeat ($urandom_range(10, 150)) @(negedge i_clk);
            else repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        if (!r.req_type) evals++;
    endtask

    task automatic eval_at(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        ognz_tb_types::t_noise_req r;
        r.req_type = 0; r.cx = x; r.cy = y; r.cz = z;
        r.idx = 8'($urandom); r.val = 8'($urandom);
        send(r);
    endtask

    task automatic load_entry(logic [7:0] i, logic [7:0] v);
        ognz_tb_types::t_noise_req r;
        r.req_type = 1; r.idx = i; r.val = v;
        r.cx = 24'($urandom); r.cy = 24'($urandom); r.cz = 24'($urandom);
        send(r);
    endtask

    // waits for results to drain, then lets any table load finish
    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_reg(ognz_pkg::t_cfg_idx idx, logic [15:0] d);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic shuffled_table();
        int p [256];
        int j, t;
        for (int i = 0; i < 256; i++) p[i] = i;
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i); t = p[i]; p[i] = p[j]; p[j] = t;
        end
        for (int i = 0; i < 256; i++) load_entry(8'(i), 8'(p[i]));
    endtask

    task automatic random_evals(int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 4))
                0: eval_at(24'($urandom), 24'd0, 24'd0);
                1: eval_at(24'($urandom), 24'($urandom), 24'd0);
                2: eval_at(24'($urandom_range(0, 3) << 22), 24'($urandom), 24'hffffff);
                default: eval_at(24'($urandom), 24'($urandom), 24'($urandom));
            endcase
            if ($urandom_range(0, 30) == 0) load_entry(8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        req_ch.valid = 0; req_ch.req_type = 0; req_ch.coord_x = 0; req_ch.coord_y = 0;
        req_ch.coord_z = 0; req_ch.table_index = 0; req_ch.table_value = 0;
        cfg_ch.valid = 0; cfg_ch.index = ognz_pkg::CFG_OCTAVES; cfg_ch.data = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        shuffled_table();
        // directed: coordinate extremes and lattice edges at reset settings
        eval_at(24'd0, 24'd0, 24'd0);
        eval_at(24'hffffff, 24'hffffff, 24'hffffff);
        eval_at(24'h010000, 24'h00ffff, 24'h800000);
        eval_at(24'h7fffff, 24'd0, 24'h008000);
        eval_at(24'h000001, 24'hff0001, 24'd0);
        drain();
        write_reg(ognz_pkg::CFG_OCTAVES, 16'(ognz_pkg::OCTAVE_MAX));
        write_reg(ognz_pkg::CFG_OUT_MIN, 16'h8000);
        write_reg(ognz_pkg::CFG_OUT_MAX, 16'h7fff);
        eval_at(24'hffffff, 24'h123456, 24'hfedcba);
        eval_at(24'h808080, 24'h404040, 24'h202020);
        drain();
        // octave count zero and above the maximum, inverted range
        write_reg(ognz_pkg::CFG_OCTAVES, 16'd0);
        write_reg(ognz_pkg::CFG_OUT_MIN, 16'd100);
        write_reg(ognz_pkg::CFG_OUT_MAX, 16'(-100));
        eval_at(24'h123456, 24'h654321, 24'hababab);
        eval_at(24'hffffff, 24'd0, 24'hffffff);
        drain();
        write_reg(ognz_pkg::CFG_OCTAVES, 16'd15);
        write_reg(ognz_pkg::CFG_OUT_MIN, 16'(-10));
        write_reg(ognz_pkg::CFG_OUT_MAX, 16'd10);
        eval_at(24'h0fffff, 24'hf00000, 24'h00ff00);
        drain();
        // long result stall so the block backs up onto its input
        write_reg(ognz_pkg::CFG_OCTAVES, 16'd1);
        write_reg(ognz_pkg::CFG_OUT_MIN, 16'h8000);
        write_reg(ognz_pkg::CFG_OUT_MAX, 16'h7fff);
        hold_off = 1;
        random_evals(30);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ognz_pkg::CFG_OCTAVES, 16'((ph == 5) ? 8 : $urandom_range(1, 4)));
            write_reg(ognz_pkg::CFG_OUT_MIN,
                      (ph == 2) ? 16'h7fff : 16'($urandom_range(0, 65535)));
            write_reg(ognz_pkg::CFG_OUT_MAX,
                      (ph == 3) ? 16'h8000 : 16'($urandom_range(0, 65535)));
            if (ph == 4) shuffled_table();
            random_evals((ph == 5) ? 30 : 55);
            drain();
        end
        $display("covered %0d evaluations over several octave and range settings,", evals);
        $display("with table reloads and a long result stall; %0d results checked", sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
